// ===== hdl/abps_pkg.sv =====
// ----------------------------------------------------------------------------
// abps_pkg
// Shared constants, types and helpers of the aligned byte pattern scanner.
// ----------------------------------------------------------------------------
package abps_pkg;

  localparam int PatternMax = 16;
  localparam int ByteW      = 8;
  localparam int AddrW      = 48;
  localparam int LenW       = 5;
  localparam int WordW      = 64;
  localparam int StepW      = 2;
  localparam int AlignW     = 3;
  localparam int IdxW       = $clog2(PatternMax);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength = 2'd0,
    CfgPatternLow    = 2'd1,
    CfgPatternHigh   = 2'd2,
    CfgStepShift     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic shift;
    logic active;
  } cell_ctrl_t;

  typedef struct packed {
    logic [AddrW-1:0] match_address;
    logic [AddrW-1:0] match_region_start;
  } out_item_t;

  function automatic logic [ByteW-1:0] pattern_byte(input logic [WordW-1:0] lo,
                                                    input logic [WordW-1:0] hi,
                                                    input logic [IdxW-1:0]  idx);
    logic [2*WordW-1:0] both;
    both = {hi, lo};
    return both[idx*ByteW +: ByteW];
  endfunction

endpackage

// ===== hdl/abps_if.sv =====
// ----------------------------------------------------------------------------
// abps_if
// Valid/ready channels of the scanner: byte input and match output.
// ----------------------------------------------------------------------------
interface abps_in_if;
  import abps_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [AddrW-1:0] byte_address;
  logic             region_first;

  modport source (output valid, output data_byte, output byte_address,
                  output region_first, input ready);
  modport sink   (input valid, input data_byte, input byte_address,
                  input region_first, output ready);
endinterface

interface abps_out_if;
  import abps_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] match_address;
  logic [AddrW-1:0] match_region_start;

  modport source (output valid, output match_address, output match_region_start,
                  input ready);
  modport sink   (input valid, input match_address, input match_region_start,
                  output ready);
endinterface

// ===== hdl/aligned_byte_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// aligned_byte_pattern_scanner_unit
// Shifts memory bytes through a row of compare cells and reports aligned
// pattern matches that lie inside the current region.
//
//   channel   dir   transfer moves
//   in_i      in    data_byte, byte_address, region_first
//   out_o     out   match_address, match_region_start
//   cfg       in    write of pattern_length/low/high word/step_shift
//
// One byte per cycle while in_i is not stalled; a match is registered in the output
// buffer before it shows on out_o, and waits there behind any older match.
// The window cells and the match test all act on the byte being taken.
// in_i stalls only when two results wait in the output buffer.
// Reset clears the window, fill count, region base, pattern words and step shift, and sets pattern_length to 1.
// ----------------------------------------------------------------------------
module aligned_byte_pattern_scanner_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  abps_in_if.sink                       in_i,
  abps_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [abps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abps_pkg::CfgDataW-1:0] cfg_data_i
);
  import abps_pkg::*;

  logic [LenW-1:0]   len_q;
  logic [WordW-1:0]  pat_lo_q;
  logic [WordW-1:0]  pat_hi_q;
  logic [StepW-1:0]  step_q;

  logic [LenW-1:0]   fill_q, fill_d;
  logic [AddrW-1:0]  base_q, base_d;

  logic              accept;
  logic              room;
  logic              len_ok;
  logic [LenW-1:0]   len_m1;
  logic [ByteW-1:0]  chain [PatternMax+1];
  logic [PatternMax-1:0] hits;
  logic [AddrW-1:0]  start;
  logic [AlignW-1:0] offset;
  logic [AlignW-1:0] align_mask;
  logic              match;
  out_item_t         item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LenW'(1);
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      step_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPatternLength: len_q    <= cfg_data_i[LenW-1:0];
        CfgPatternLow:    pat_lo_q <= cfg_data_i[WordW-1:0];
        CfgPatternHigh:   pat_hi_q <= cfg_data_i[WordW-1:0];
        CfgStepShift:     step_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign accept      = in_i.valid && room;
  assign in_i.ready  = room;
  assign len_ok      = (len_q != '0) && (len_q <= LenW'(PatternMax));
  assign len_m1      = len_q - LenW'(1);

  assign base_d = in_i.region_first ? in_i.byte_address : base_q;
  always_comb begin
    if (in_i.region_first) begin
      fill_d = LenW'(1);
    end else if (fill_q == LenW'(PatternMax)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      base_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
      base_q <= base_d;
    end
  end

  assign chain[0] = in_i.data_byte;

  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    localparam logic [IdxW-1:0] CellIdx = IdxW'(i);
    cell_ctrl_t       ctrl;
    logic [ByteW-1:0] expect_byte;

    assign ctrl.shift   = accept;
    assign ctrl.active  = len_ok && (LenW'(i) < len_q);
    assign expect_byte  = pattern_byte(pat_lo_q, pat_hi_q, len_m1[IdxW-1:0] - CellIdx);

    abps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .byte_i   (chain[i]),
      .expect_i (expect_byte),
      .byte_o   (chain[i+1]),
      .hit_o    (hits[i])
    );
  end

  assign start      = in_i.byte_address - AddrW'(len_m1);
  assign offset     = start[AlignW-1:0] - base_d[AlignW-1:0];
  assign align_mask = AlignW'((4'd1 << step_q) - 4'd1);

  assign match = len_ok && (fill_d >= len_q) && (&hits) &&
                 ((offset & align_mask) == '0);

  assign item.match_address      = start;
  assign item.match_region_start = base_d;

  abps_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && match),
    .item_i (item),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

// ===== hdl/abps_cell.sv =====
// ----------------------------------------------------------------------------
// abps_cell
// One window byte: loads its neighbor's byte on a transfer and compares the
// incoming byte with the pattern byte that lands on its position.
// ----------------------------------------------------------------------------
module abps_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  abps_pkg::cell_ctrl_t       ctrl_i,
  input  logic [abps_pkg::ByteW-1:0] byte_i,
  input  logic [abps_pkg::ByteW-1:0] expect_i,
  output logic [abps_pkg::ByteW-1:0] byte_o,
  output logic                       hit_o
);
  import abps_pkg::*;

  logic [ByteW-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !ctrl_i.active || (byte_i == expect_i);

endmodule

// ===== hdl/abps_out_buf.sv =====
// ----------------------------------------------------------------------------
// abps_out_buf
// Two-entry result buffer: holds one match while the next byte is taken.
// ----------------------------------------------------------------------------
module abps_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  abps_pkg::out_item_t   item_i,
  output logic                  room_o,
  abps_out_if.source            out_o
);
  import abps_pkg::*;

  out_item_t  ent_q [2];
  logic [1:0] cnt_q;
  logic       pop;
  logic       wr_idx;

  assign pop    = out_o.valid && out_o.ready;
  assign wr_idx = (cnt_q == 2'd1) && !pop;
  assign room_o = (cnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (cnt_q == 2'd2)) begin
      ent_q[0] <= ent_q[1];
    end
    if (push_i) begin
      ent_q[wr_idx] <= item_i;
    end
  end

  assign out_o.valid              = (cnt_q != 2'd0);
  assign out_o.match_address      = ent_q[0].match_address;
  assign out_o.match_region_start = ent_q[0].match_region_start;

endmodule

// ===== hdl/abps_checker.sv =====
// ----------------------------------------------------------------------------
// abps_checker
// Port-level checks of the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module abps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [abps_pkg::AddrW-1:0] match_address_i,
  input logic [abps_pkg::AddrW-1:0] match_region_start_i
);
  import abps_pkg::*;

  a_out_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped before transfer");

  a_out_data_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(match_address_i) &&
                                    $stable(match_region_start_i))
    else $error("output payload changed while stalled");

  a_result_needs_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an input transfer");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output buffer");

endmodule

bind aligned_byte_pattern_scanner_unit abps_checker u_abps_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .match_address_i      (out_o.match_address),
  .match_region_start_i (out_o.match_region_start)
);

// ===== test/abps_scan_checker.sv =====
// ----------------------------------------------------------------------------
// abps_scan_checker
// Watches the byte and match channels of the scanner. Keeps its own window,
// fill count, region base and register copies, predicts the match of every
// byte transfer and compares each match transfer, field by field, in order.
// ----------------------------------------------------------------------------
module abps_scan_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  abps_in_if                            in_i,
  abps_out_if                           res_i,
  input  logic                          cfg_we_i,
  input  logic [abps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abps_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            err_count_o,
  output int                            pending_o,
  output int                            matches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import abps_pkg::*;

  logic [ByteW-1:0]  window_q [PatternMax];
  logic [LenW-1:0]   fill_q;
  logic [AddrW-1:0]  base_q;
  logic [LenW-1:0]   pat_len;
  logic [WordW-1:0]  pat_lo;
  logic [WordW-1:0]  pat_hi;
  logic [StepW-1:0]  align_log;
  out_item_t         expected_matches[$];
  out_item_t         oldest;

  task automatic report(input string msg);
    err_count_o++;
    if (err_count_o <= 10) begin
      $display("%0t abps_scan_checker: %s", $realtime, msg);
    end
  endtask

  task automatic predict_match(input logic [ByteW-1:0] data, input logic [AddrW-1:0] addr,
                               input logic first);
    logic [2*WordW-1:0] pat;
    logic [AddrW-1:0]   start;
    logic [AddrW-1:0]   offset;
    logic [3:0]         amask;
    logic               hit;
    out_item_t          item;
    int                 i;
    if (first) begin
      base_q = addr;
      fill_q = '0;
    end
    for (i = PatternMax - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = data;
    if (fill_q < PatternMax) fill_q++;
    hit = (pat_len != 0) && (pat_len <= PatternMax) && (fill_q >= pat_len);
    pat = {pat_hi, pat_lo};
    for (i = 0; i < PatternMax; i++) begin
      if (hit && i < pat_len && window_q[pat_len - 1 - i] != pat[8*i +: 8]) hit = 1'b0;
    end
    start  = addr - ({{(AddrW-LenW){1'b0}}, pat_len} - {{(AddrW-1){1'b0}}, 1'b1});
    offset = start - base_q;
    amask  = (4'd1 << align_log) - 4'd1;
    if (hit && (offset[3:0] & amask) == 4'd0) begin
      item.match_address      = start;
      item.match_region_start = base_q;
      expected_matches.insert(expected_matches.size(), item);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PatternMax; i++) window_q[i] = '0;
      fill_q      = '0;
      base_q      = '0;
      pat_len     = LenW'(1);
      pat_lo      = '0;
      pat_hi      = '0;
      align_log   = '0;
      expected_matches.delete();
      err_count_o = 0;
      matches_o   = 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPatternLength: pat_len   = cfg_data_i[LenW-1:0];
          CfgPatternLow:    pat_lo    = cfg_data_i;
          CfgPatternHigh:   pat_hi    = cfg_data_i;
          CfgStepShift:     align_log = cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        predict_match(in_i.data_byte, in_i.byte_address, in_i.region_first);
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_matches.size() == 0) begin
          report($sformatf("unexpected match: address %h region %h",
                           res_i.match_address, res_i.match_region_start));
        end else begin
          oldest = expected_matches.pop_front();
          matches_o++;
          if (res_i.match_address !== oldest.match_address) begin
            report($sformatf("match_address: expected %h, got %h",
                             oldest.match_address, res_i.match_address));
          end
          if (res_i.match_region_start !== oldest.match_region_start) begin
            report($sformatf("match_region_start: expected %h, got %h",
                             oldest.match_region_start, res_i.match_region_start));
          end
        end
      end
      pending_o <= expected_matches.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the aligned byte pattern scanner with directed and random memory
// regions under several register setups, with bursty input, a stalling
// match receiver and long receiver hold-offs; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abps_pkg::*;

  localparam int HalfPeriod    = 2;
  localparam int RandomItems   = 1800;
  localparam int HoldCycles    = 300;
  localparam int IdleTail      = 4;
  localparam int EndTail       = 8;
  localparam int TimeoutCycles = 500_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  abps_in_if  in_ch ();
  abps_out_if res_ch ();

  int err_count;
  int pending;
  int n_matches;
  int n_bytes   = 0;
  int n_setups  = 0;
  int burst_left = 0;
  bit hold_req  = 1'b0;
  bit drain     = 1'b0;

  logic [LenW-1:0]  cur_len   = LenW'(1);
  logic [WordW-1:0] cur_lo    = '0;
  logic [WordW-1:0] cur_hi    = '0;
  logic [StepW-1:0] cur_shift = '0;
  logic [AddrW-1:0] next_addr = '0;
  logic [ByteW-1:0] carry[$];

  aligned_byte_pattern_scanner_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  abps_scan_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .res_i       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (err_count),
    .pending_o   (pending),
    .matches_o   (n_matches)
  );

  always #HalfPeriod clk_i = ~clk_i;

  task automatic push_byte(input logic [ByteW-1:0] data, input logic [AddrW-1:0] addr,
                           input logic first);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.byte_address <= addr;
    in_ch.region_first <= first;
    do @(posedge clk_i); while (!in_ch.ready);
    n_bytes++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [LenW-1:0] len, input logic [WordW-1:0] lo,
                            input logic [WordW-1:0] hi, input logic [StepW-1:0] shift);
    logic [CfgDataW-1:0] junk;
    wait_idle();
    junk = {$urandom(), $urandom()};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgPatternLength;
    cfg_data_i  <= {junk[CfgDataW-1:LenW], len};
    @(posedge clk_i);
    cfg_index_i <= CfgPatternLow;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= CfgPatternHigh;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_index_i <= CfgStepShift;
    cfg_data_i  <= {junk[CfgDataW-1:StepW], shift};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len   = len;
    cur_lo    = lo;
    cur_hi    = hi;
    cur_shift = shift;
    n_setups++;
    carry.delete();
  endtask

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: return r[AddrW-1:0];
      1: return {AddrW{1'b1}} - AddrW'($urandom_range(0, 48));
      2: return AddrW'($urandom_range(0, 4095));
      default: return {r[AddrW-1:3], 3'b000};
    endcase
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_region(input int body_len, input bit flagged);
    logic [ByteW-1:0]   body[$];
    logic [2*WordW-1:0] pat;
    logic [AddrW-1:0]   addr;
    int                 plen, step, pos, split, jump_at, i, k;
    pat  = {cur_hi, cur_lo};
    plen = (cur_len >= 1 && cur_len <= PatternMax) ? int'(cur_len)
                                                   : $urandom_range(1, PatternMax);
    step = 1 << cur_shift;
    for (i = 0; i < body_len; i++) begin
      k = $urandom_range(0, PatternMax - 1);
      body.insert(body.size(),
                  ($urandom_range(0, 3) == 0) ? pat[8*k +: 8] : ByteW'($urandom()));
    end
    repeat ($urandom_range(0, 3)) begin
      if (body_len >= plen) begin
        pos = $urandom_range(0, body_len - plen);
        if ($urandom_range(0, 3) != 0) pos -= pos % step;
        for (k = 0; k < plen; k++) body[pos + k] = pat[8*k +: 8];
        if ($urandom_range(0, 4) == 0) begin
          k = pos + $urandom_range(0, plen - 1);
          body[k] = body[k] ^ (ByteW'(1) << $urandom_range(0, 7));
        end
      end
    end
    for (k = 0; k < carry.size() && k < body_len; k++) body[k] = carry[k];
    carry.delete();
    if (body_len >= plen && plen > 1 && $urandom_range(0, 5) == 0) begin
      split = $urandom_range(1, plen - 1);
      for (k = 0; k < split; k++) body[body_len - split + k] = pat[8*k +: 8];
      for (k = split; k < plen; k++) carry.insert(carry.size(), pat[8*k +: 8]);
    end
    addr    = flagged ? rand_addr() : next_addr;
    jump_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, body_len - 1) : -1;
    for (i = 0; i < body_len; i++) begin
      if (i == jump_at && i > 0) addr += AddrW'($urandom_range(1, 64));
      push_byte(body[i], addr, flagged && i == 0);
      addr++;
    end
    next_addr = addr;
  endtask

  initial begin : receiver
    int         mode, seg, c;
    logic [7:0] pat;
    logic       rdy;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 160);
      pat  = 8'($urandom()) | 8'h01;
      for (c = 0; c < seg && !hold_req; c++) begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 1) == 1);
          2: rdy = pat[c % 8];
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
        res_ch.ready <= rdy || drain;
        @(posedge clk_i);
      end
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        for (c = 0; c < HoldCycles; c++) @(posedge clk_i);
        hold_req = 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [2*WordW-1:0] pat;
    logic [AddrW-1:0]   addr;
    logic [LenW-1:0]    len;
    logic [StepW-1:0]   shift;
    int                 ph, target, phase_end, i;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_address = '0;
    in_ch.region_first = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CfgPatternLength;
    cfg_data_i         = '0;
    rst_ni             = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_byte(8'h00, 48'd5, 1'b0);
    push_byte(8'hFF, 48'd6, 1'b0);
    push_byte(8'h00, 48'd7, 1'b0);

    write_regs(5'd16, 64'h7F80_01FE_3C00_FF5A, 64'h0102_0408_1020_4080, 2'd3);
    pat  = {cur_hi, cur_lo};
    addr = 48'hFFFF_FFFF_FFF8;
    for (i = 0; i < PatternMax; i++) begin
      push_byte(pat[8*i +: 8], addr, i == 0);
      addr++;
    end

    write_regs(5'd0, '0, '0, 2'd0);
    push_byte(8'h00, 48'h100, 1'b1);
    push_byte(8'h00, 48'h101, 1'b0);
    write_regs(5'd31, '0, '0, 2'd1);
    for (i = 0; i < 18; i++) push_byte(8'h00, 48'h200 + i, i == 0);

    write_regs(5'd1, 64'hA5, '0, 2'd0);
    hold_req = 1'b1;
    for (i = 0; i < 60; i++) push_byte(8'hA5, 48'h4000 + i, i == 0);

    ph     = 0;
    target = n_bytes + RandomItems;
    while (n_bytes < target) begin
      case (ph)
        0: begin
          len   = 5'd1;
          shift = 2'd0;
        end
        1: begin
          len   = 5'd16;
          shift = 2'd3;
        end
        default: begin
          case ($urandom_range(0, 11))
            0: len = 5'd0;
            1: len = LenW'($urandom_range(17, 31));
            default: len = LenW'($urandom_range(1, PatternMax));
          endcase
          shift = StepW'($urandom_range(0, 3));
        end
      endcase
      write_regs(len, rand_word(), rand_word(), shift);
      if (ph == 5) hold_req = 1'b1;
      phase_end = n_bytes + $urandom_range(80, 220);
      while (n_bytes < phase_end && n_bytes < target) begin
        send_region($urandom_range(1, 48), $urandom_range(0, 9) != 0);
      end
      ph++;
    end

    wait_idle();
    drain = 1'b1;
    repeat (EndTail) @(posedge clk_i);
    $display("tb_top: %0d bytes scanned, %0d matches compared, %0d register setups",
             n_bytes, n_matches, n_setups);
    $display("tb_top: lengths 0 to 31, alignments 1 to 8, address wrap, region edges");
    if (err_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * 2 * HalfPeriod);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
